>>> design/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg: shared types and constants for the delta-list timer queue
// Action and result codes, sequencer state codes, fixed field widths.
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int unsigned SLOTS_DEFAULT = 16;
  localparam int unsigned FIRE_LIMIT    = 64;
  localparam int unsigned TW            = 32;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_CANCEL = 2'd1;
  localparam logic [1:0] ACT_UPDATE = 2'd2;

  localparam logic [1:0] KIND_INSERTED = 2'd0;
  localparam logic [1:0] KIND_FULL     = 2'd1;
  localparam logic [1:0] KIND_FIRED    = 2'd2;

  // sequencer states
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_LRD     = 4'd1;  // link walk: read entry
  localparam logic [3:0] ST_LCMP    = 4'd2;  // link walk: compare/subtract
  localparam logic [3:0] ST_LDONE   = 4'd3;  // link walk: fix successor
  localparam logic [3:0] ST_CRD     = 4'd4;  // cancel walk: read entry
  localparam logic [3:0] ST_CCHK    = 4'd5;
  localparam logic [3:0] ST_CADD    = 4'd6;  // cancel: add delta to successor
  localparam logic [3:0] ST_URD     = 4'd7;  // update: read head
  localparam logic [3:0] ST_UCMP    = 4'd8;
  localparam logic [3:0] ST_UPER    = 4'd9;  // update: read period of fired id
  localparam logic [3:0] ST_UEND    = 4'd10;

  // one shared unit operation
  typedef struct packed {
    logic            sub;  // 1: a - b, 0: a + b
    logic [TW-1:0]   a;
    logic [TW-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [TW-1:0] sum;
    logic          ge;   // a >= b
    logic          cout; // carry of add
  } alu_rsp_t;

endpackage

>>> design/delta_list_timer_queue_top.sv
// ----------------------------------------------------------------------------
// delta_list_timer_queue_top: timer pool kept as a delta-sorted linked list
// Insert, cancel and update items share one sequencer and mostly one adder.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with action/delay/period/timer_id/current_time while busy is
//   low; it is taken at that edge; busy rises unless a cancel's id is unused.
//   Results come out on kind/timer_id_res/last, each marked by a one-cycle
//   strobe; the receiver cannot stall, so every result is taken when shown.
//   Insert: one result (inserted id or pool full). Cancel: no result.
//   Update: one fire result per due timer, at most 64, last set on the final.
// Walk:
//   The list walk visits one entry of the slot memories at a time, through a
//   read state and a compare or check state; an update also walks the list
//   to re-insert each periodic timer that fires. One item at a time: no new
//   item is taken while busy is high.
// Reset:
//   rst clears the free mask (all free), head (empty), last time and carry.
//   The slot memories are not cleared: they are written before being read.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_top #(
  parameter int unsigned TIMER_SLOTS = dltq_pkg::SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [31:0] delay,
  input  logic [31:0] period,
  input  logic [5:0]  timer_id,
  input  logic [31:0] current_time,
  output logic        strobe,
  output logic [1:0]  kind,
  output logic [4:0]  timer_id_res,
  output logic        last
);
  localparam int unsigned IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned GW = $clog2(TIMER_SLOTS + 1);
  localparam int unsigned TW = dltq_pkg::TW;

  // slot memories; link entry {none, id}
  logic [IW:0]   link_mem  [TIMER_SLOTS];
  logic [TW-1:0] delta_mem [TIMER_SLOTS];
  logic [TW-1:0] per_mem   [TIMER_SLOTS];

  logic [TIMER_SLOTS-1:0] free_mask;
  logic [IW:0]   list_head;          // MSB set: empty
  logic [TW-1:0] last_seen_time;
  logic [TW-1:0] carried_elapsed;

  logic [3:0]    state;
  logic [IW:0]   prev, curr;         // MSB set: none
  logic [IW-1:0] id;
  logic [TW-1:0] remaining;          // link walk remainder / update elapsed
  logic [TW-1:0] rd_delta;
  logic [IW:0]   rd_link;
  logic [TW-1:0] rd_per;
  logic [GW-1:0] guard;
  logic [6:0]    nfire;
  logic          in_update;
  logic [TW-1:0] b_arg;

  // pending result register
  logic          strobe_r;
  logic [1:0]    kind_r;
  logic [4:0]    tid_r;
  logic          last_r;

  dltq_pkg::alu_req_t areq;
  dltq_pkg::alu_rsp_t arsp;
  dltq_alu u_alu (.req(areq), .rsp(arsp));

  logic [IW-1:0] rd_addr;
  always_comb begin
    rd_addr = curr[IW-1:0];
    if (state == dltq_pkg::ST_UPER) rd_addr = id;
  end

  // registered memory read
  always_ff @(posedge clk) begin
    rd_delta <= delta_mem[rd_addr];
    rd_link  <= link_mem[rd_addr];
    rd_per   <= per_mem[rd_addr];
  end

  // lowest free slot
  logic [IW-1:0] free_idx;
  logic          any_free;
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        free_idx = IW'(i);
        any_free = 1'b1;
      end
    end
  end

  // shared adder operand selection
  always_comb begin
    areq.sub = 1'b1;
    areq.a   = remaining;
    areq.b   = rd_delta;
    case (state)
      dltq_pkg::ST_IDLE: begin
        areq.sub = 1'b1;
        areq.a   = current_time;
        areq.b   = last_seen_time;
      end
      dltq_pkg::ST_URD: begin
        areq.sub = 1'b0;
        areq.a   = carried_elapsed;
        areq.b   = b_arg;
      end
      dltq_pkg::ST_LDONE: begin
        areq.sub = 1'b1;
        areq.a   = rd_delta;
        areq.b   = remaining;
      end
      dltq_pkg::ST_CADD: begin
        areq.sub = 1'b0;
        areq.a   = rd_delta;
        areq.b   = b_arg;
      end
      default: begin
        areq.sub = 1'b1;
        areq.a   = remaining;
        areq.b   = rd_delta;
      end
    endcase
  end

  logic        first_upd;   // update: elapsed not yet formed
  logic        link_none;
  assign link_none = curr[IW];

  // head is due and the fire budget is not spent
  logic        fire_ok;
  assign fire_ok = !list_head[IW] && nfire != 7'(dltq_pkg::FIRE_LIMIT) && arsp.ge &&
                   curr == list_head;

  // a result is registered at the end of this cycle
  logic        res_go;
  always_comb begin
    res_go = 1'b0;
    case (state)
      dltq_pkg::ST_IDLE:  res_go = start && !busy && action == dltq_pkg::ACT_INSERT &&
                                   !any_free;
      dltq_pkg::ST_LDONE: res_go = !in_update;
      dltq_pkg::ST_UCMP:  res_go = fire_ok;
      default:            res_go = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= res_go;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= dltq_pkg::ST_IDLE;
      free_mask       <= '1;
      list_head       <= {1'b1, {IW{1'b0}}};
      last_seen_time  <= '0;
      carried_elapsed <= '0;
      first_upd       <= 1'b0;
      in_update       <= 1'b0;
      nfire           <= '0;
    end else begin
      case (state)
        dltq_pkg::ST_IDLE: begin
          if (start && !busy) begin
            in_update <= (action == dltq_pkg::ACT_UPDATE);
            case (action)
              dltq_pkg::ACT_INSERT: begin
                if (!any_free) begin
                  kind_r   <= dltq_pkg::KIND_FULL;
                  tid_r    <= '0;
                  last_r   <= 1'b1;
                end else begin
                  free_mask[free_idx] <= 1'b0;
                  per_mem[free_idx]   <= period;
                  id        <= free_idx;
                  remaining <= delay;
                  prev      <= {1'b1, {IW{1'b0}}};
                  curr      <= list_head;
                  guard     <= '0;
                  state     <= dltq_pkg::ST_LRD;
                end
              end
              dltq_pkg::ACT_CANCEL: begin
                if (timer_id < 6'(TIMER_SLOTS) && !free_mask[timer_id[IW-1:0]]) begin
                  id    <= timer_id[IW-1:0];
                  prev  <= {1'b1, {IW{1'b0}}};
                  curr  <= list_head;
                  guard <= '0;
                  state <= dltq_pkg::ST_CRD;
                end
              end
              dltq_pkg::ACT_UPDATE: begin
                b_arg          <= arsp.sum;
                last_seen_time <= current_time;
                nfire          <= '0;
                first_upd      <= 1'b1;
                curr           <= list_head;
                state          <= dltq_pkg::ST_URD;
              end
              default: ;
            endcase
          end
        end

        // ---------------- link walk (insert and periodic re-insert)
        dltq_pkg::ST_LRD: begin
          if (link_none || guard == GW'(TIMER_SLOTS)) begin
            state <= dltq_pkg::ST_LDONE;
          end else begin
            state <= dltq_pkg::ST_LCMP;
          end
        end
        dltq_pkg::ST_LCMP: begin
          if (arsp.ge) begin
            remaining <= arsp.sum;
            prev      <= curr;
            curr      <= rd_link;
            guard     <= guard + GW'(1);
            state     <= dltq_pkg::ST_LRD;
          end else begin
            state <= dltq_pkg::ST_LDONE;
          end
        end
        dltq_pkg::ST_LDONE: begin
          delta_mem[id] <= remaining;
          link_mem[id]  <= curr;
          if (prev[IW]) list_head <= {1'b0, id};
          else link_mem[prev[IW-1:0]] <= {1'b0, id};
          if (!link_none) delta_mem[curr[IW-1:0]] <= arsp.sum;
          if (in_update) begin
            remaining <= b_arg;   // restore elapsed
            curr      <= prev[IW] ? {1'b0, id} : list_head;
            state     <= dltq_pkg::ST_URD;
          end else begin
            kind_r   <= dltq_pkg::KIND_INSERTED;
            tid_r    <= 5'(id);
            last_r   <= 1'b1;
            state    <= dltq_pkg::ST_IDLE;
          end
        end

        // ---------------- cancel walk
        dltq_pkg::ST_CRD: begin
          if (link_none || guard == GW'(TIMER_SLOTS)) begin
            state <= dltq_pkg::ST_IDLE;
          end else if (curr[IW-1:0] == id) begin
            state <= dltq_pkg::ST_CCHK;
          end else begin
            state <= dltq_pkg::ST_CCHK;
          end
        end
        dltq_pkg::ST_CCHK: begin
          if (curr[IW-1:0] == id) begin
            if (prev[IW]) list_head <= rd_link;
            else link_mem[prev[IW-1:0]] <= rd_link;
            free_mask[id] <= 1'b1;
            b_arg         <= rd_delta;
            if (rd_link[IW]) begin
              state <= dltq_pkg::ST_IDLE;
            end else begin
              curr  <= rd_link;
              guard <= '0;
              state <= dltq_pkg::ST_CADD;
            end
          end else begin
            prev  <= curr;
            curr  <= rd_link;
            guard <= guard + GW'(1);
            state <= dltq_pkg::ST_CRD;
          end
        end
        dltq_pkg::ST_CADD: begin
          // rd_delta holds the successor's delta once its registered read returns
          if (guard[0] == 1'b0) begin
            guard <= '1;
          end else begin
            delta_mem[curr[IW-1:0]] <= arsp.sum;
            state <= dltq_pkg::ST_IDLE;
          end
        end

        // ---------------- update
        dltq_pkg::ST_URD: begin
          if (first_upd) begin
            remaining <= arsp.cout ? '1 : arsp.sum;
            first_upd <= 1'b0;
          end
          curr  <= list_head;
          state <= dltq_pkg::ST_UCMP;
        end
        dltq_pkg::ST_UCMP: begin
          // rd_delta is head's delta (curr set before this state)
          if (list_head[IW]) begin
            carried_elapsed <= '0;
            state <= dltq_pkg::ST_UEND;
          end else if (fire_ok) begin
            id        <= list_head[IW-1:0];
            remaining <= arsp.sum;
            list_head <= rd_link;
            kind_r    <= dltq_pkg::KIND_FIRED;
            tid_r     <= 5'(list_head[IW-1:0]);
            last_r    <= 1'b0;
            nfire     <= nfire + 7'd1;
            state     <= dltq_pkg::ST_UPER;
          end else if (curr != list_head) begin
            curr <= list_head;
          end else if (!arsp.ge) begin
            delta_mem[list_head[IW-1:0]] <= rd_delta - remaining;
            carried_elapsed <= '0;
            state <= dltq_pkg::ST_UEND;
          end else begin
            carried_elapsed <= remaining;
            state <= dltq_pkg::ST_UEND;
          end
        end
        dltq_pkg::ST_UPER: begin
          if (rd_per != '0 || per_mem[id] != '0) begin
            b_arg     <= remaining;
            remaining <= per_mem[id];
            prev      <= {1'b1, {IW{1'b0}}};
            curr      <= list_head;
            guard     <= '0;
            state     <= dltq_pkg::ST_LRD;
          end else begin
            free_mask[id] <= 1'b1;
            curr  <= list_head;
            state <= dltq_pkg::ST_URD;
          end
        end
        dltq_pkg::ST_UEND: begin
          state <= dltq_pkg::ST_IDLE;
        end
        default: state <= dltq_pkg::ST_IDLE;
      endcase
    end
  end

  // the final fire of an update is flagged when the sequencer finds no more
  logic          hold_v;
  logic [4:0]    hold_id;
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
    end else if (strobe_r && kind_r == dltq_pkg::KIND_FIRED) begin
      hold_v  <= 1'b1;
      hold_id <= tid_r;
    end else if (state == dltq_pkg::ST_IDLE) begin
      hold_v <= 1'b0;
    end
  end

  // each fire is held back, shown when the next fire or the end is known
  logic fire_now, end_now;
  assign fire_now = strobe_r && kind_r == dltq_pkg::KIND_FIRED && hold_v;
  assign end_now  = state == dltq_pkg::ST_IDLE && hold_v;

  always_comb begin
    strobe       = 1'b0;
    kind         = kind_r;
    timer_id_res = tid_r;
    last         = last_r;
    if (fire_now || end_now) begin
      strobe       = 1'b1;
      kind         = dltq_pkg::KIND_FIRED;
      timer_id_res = hold_id;
      last         = end_now;
    end else if (strobe_r && kind_r != dltq_pkg::KIND_FIRED) begin
      strobe = 1'b1;
    end
  end

  assign busy = (state != dltq_pkg::ST_IDLE) || hold_v || strobe_r;

  // ---------------- checks
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (state != dltq_pkg::ST_IDLE) |-> busy) else $error("busy low mid item");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !hold_v) else $error("fire held after last");
  a_nfire: assert property (@(posedge clk) disable iff (rst)
    nfire <= 7'(dltq_pkg::FIRE_LIMIT)) else $error("fire limit exceeded");
endmodule

>>> design/dltq_alu.sv
// ----------------------------------------------------------------------------
// dltq_alu: shared 32-bit add/subtract/compare unit
// One adder serves most delta updates, every compare and carry saturation.
// ----------------------------------------------------------------------------
module dltq_alu (
  input  dltq_pkg::alu_req_t req,
  output dltq_pkg::alu_rsp_t rsp
);
  logic [dltq_pkg::TW:0] s;
  always_comb begin
    if (req.sub) begin
      s = {1'b0, req.a} + {1'b0, ~req.b} + {{dltq_pkg::TW{1'b0}}, 1'b1};
    end else begin
      s = {1'b0, req.a} + {1'b0, req.b};
    end
    rsp.sum  = s[dltq_pkg::TW-1:0];
    rsp.cout = s[dltq_pkg::TW] & ~req.sub;
    rsp.ge   = s[dltq_pkg::TW] & req.sub;
  end
endmodule
